/* hdl/bced_pkg.sv */
// shared types and constants for the button click event detector
// no dependencies; imported by button_click_event_detector
`timescale 1ns / 1ps
`default_nettype none

package bced_pkg;

	// event codes on the result channel
	typedef enum logic [2:0] {
		EV_NONE     = 3'd0,
		EV_RELEASED = 3'd1,
		EV_PRESSED  = 3'd2,
		EV_LONG     = 3'd3,
		EV_CLICK    = 3'd4,
		EV_DOUBLE   = 3'd5,
		EV_TRIPLE   = 3'd6
	} ev_code_t;

	// click classification codes
	typedef enum logic [2:0] {
		TYPE_NONE   = 3'd0,
		TYPE_SINGLE = 3'd1,
		TYPE_DOUBLE = 3'd2,
		TYPE_TRIPLE = 3'd3,
		TYPE_LONG   = 3'd4
	} click_type_t;

	// register map, word index = paddr[3:2]
	localparam logic [1:0] REG_DEBOUNCE     = 2'd0;
	localparam logic [1:0] REG_LONG_PRESS   = 2'd1;
	localparam logic [1:0] REG_CLICK_WINDOW = 2'd2;

	localparam logic [15:0] DEBOUNCE_RST     = 16'd50;
	localparam logic [15:0] LONG_PRESS_RST   = 16'd1000;
	localparam logic [15:0] CLICK_WINDOW_RST = 16'd300;

	localparam logic [7:0] CLICKS_MAX = 8'd255;

endpackage

`default_nettype wire

/* hdl/button_click_event_detector.sv */
// button click event detector: debounce, multi-click and long press
// depends on bced_pkg
//
// usage:
//   input channel (in_valid/in_ready) carries one sample of the button line
//   (released = 1 when not pressed) with a free-running millisecond stamp now_ms.
//   every accepted request gives exactly one result on the output channel
//   (out_valid/out_ready): event code, last press duration, click count and
//   last click classification, all state values taken after the update.
//   the request passes through the input register, then the result register,
//   before out_valid rises; while the receiver takes results, one request is
//   taken every cycle, set by the single evaluation stage between the input
//   register and the result register, where the state is read and updated.
//   when the receiver stalls, the result register holds, the input register
//   fills, and in_ready falls; nothing is lost or repeated.
//   reset (arst_n low, asynchronous) empties both stages, sets the line level
//   to released, clears times, counters and flags, and loads the register
//   defaults debounce 50, long press 1000, click window 300. the user must write
//   registers over the apb port only while the block is idle; not enforced.
`timescale 1ns / 1ps
`default_nettype none

module button_click_event_detector
	import bced_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// sample channel
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        released,
	input  wire logic [31:0] now_ms,
	// result channel
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       event_res,
	output logic [31:0]      press_duration_ms,
	output logic [7:0]       group_clicks,
	output logic [2:0]       click_type,
	// configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	// configuration registers
	logic [15:0] debounce_q;
	logic [15:0] long_press_q;
	logic [15:0] click_window_q;
	logic        cfg_wr;
	logic [1:0]  cfg_idx;

	assign pready  = 1'b1;
	assign cfg_idx = paddr[3:2];
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q     <= DEBOUNCE_RST;
			long_press_q   <= LONG_PRESS_RST;
			click_window_q <= CLICK_WINDOW_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_DEBOUNCE:     debounce_q     <= pwdata[15:0];
				REG_LONG_PRESS:   long_press_q   <= pwdata[15:0];
				REG_CLICK_WINDOW: click_window_q <= pwdata[15:0];
				default: ;  // writes past the map are dropped
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_DEBOUNCE:     prdata = {16'd0, debounce_q};
			REG_LONG_PRESS:   prdata = {16'd0, long_press_q};
			REG_CLICK_WINDOW: prdata = {16'd0, click_window_q};
			default:          prdata = 32'd0;
		endcase
	end

	// input register (stage 1)
	logic        valid_s1;
	logic        released_s1;
	logic [31:0] now_s1;
	logic        advance;

	// result register
	logic        out_valid_q;
	ev_code_t    ev_q;
	logic [31:0] press_duration_q;
	logic [7:0]  clicks_out_q;
	click_type_t type_out_q;

	// stage 1 moves into the result register when that slot is free or draining
	assign advance  = valid_s1 & (~out_valid_q | out_ready);
	assign in_ready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			released_s1 <= released;
			now_s1      <= now_ms;
		end
	end

	// detector state
	logic        level_prev_q;
	logic [31:0] press_start_q;
	logic [31:0] pressed_event_time_q;
	logic [31:0] group_start_q;
	logic        pressed_flag_q;
	logic        long_flag_q;
	logic [7:0]  clicks_q;
	click_type_t last_type_q;

	// next-state values
	logic [31:0] press_start_d;
	logic [31:0] pressed_event_time_d;
	logic [31:0] group_start_d;
	logic [31:0] press_duration_d;
	logic        pressed_flag_d;
	logic        long_flag_d;
	logic [7:0]  clicks_d;
	click_type_t last_type_d;
	ev_code_t    ev_d;

	// wrapping time differences
	logic [31:0] since_press;
	logic [31:0] since_pressed_ev;
	logic [31:0] since_group;
	logic [31:0] debounce_w;
	logic [31:0] long_press_w;
	logic [31:0] click_window_w;
	logic [7:0]  clicks_grp;

	assign since_press      = now_s1 - press_start_q;
	assign since_pressed_ev = now_s1 - pressed_event_time_q;
	assign since_group      = now_s1 - group_start_q;
	assign debounce_w       = {16'd0, debounce_q};
	assign long_press_w     = {16'd0, long_press_q};
	assign click_window_w   = {16'd0, click_window_q};

	// prioritized rules, first match wins
	always_comb begin
		press_start_d        = press_start_q;
		pressed_event_time_d = pressed_event_time_q;
		group_start_d        = group_start_q;
		press_duration_d     = press_duration_q;
		pressed_flag_d       = pressed_flag_q;
		long_flag_d          = long_flag_q;
		clicks_d             = clicks_q;
		last_type_d          = last_type_q;
		ev_d                 = EV_NONE;
		clicks_grp           = clicks_q;

		if (level_prev_q && !released_s1) begin
			// press edge: start a press and count it into the group
			press_start_d  = now_s1;
			group_start_d  = now_s1;
			pressed_flag_d = 1'b0;
			if (clicks_q != CLICKS_MAX) begin
				clicks_d = clicks_q + 8'd1;
			end
		end else if (!level_prev_q && released_s1) begin
			// release edge
			press_duration_d = since_press;
			if (since_press >= debounce_w) begin
				ev_d = EV_RELEASED;
			end
		end else if (!released_s1 && !pressed_flag_q && !long_flag_q &&
			since_press >= debounce_w) begin
			// held past debounce
			pressed_event_time_d = now_s1;
			pressed_flag_d       = 1'b1;
			ev_d                 = EV_PRESSED;
		end else if (pressed_flag_q && !long_flag_q && since_pressed_ev > long_press_w) begin
			// long press, fires even after release
			pressed_flag_d = 1'b0;
			long_flag_d    = 1'b1;
			ev_d           = EV_LONG;
		end else if (released_s1 && since_group > click_window_w) begin
			// group close; a long press group swallows its clicks
			if (long_flag_q) begin
				long_flag_d = 1'b0;
				last_type_d = TYPE_LONG;
				clicks_grp  = 8'd0;
			end
			if (clicks_grp != 8'd0) begin
				pressed_event_time_d = 32'd0;
				pressed_flag_d       = 1'b0;
				case (clicks_grp)
					8'd1: begin
						last_type_d = TYPE_SINGLE;
						ev_d        = EV_CLICK;
					end
					8'd2: begin
						last_type_d = TYPE_DOUBLE;
						ev_d        = EV_DOUBLE;
					end
					8'd3: begin
						last_type_d = TYPE_TRIPLE;
						ev_d        = EV_TRIPLE;
					end
					default: ;  // four or more clicks close silently
				endcase
			end
			clicks_d      = 8'd0;
			group_start_d = 32'd0;
		end
	end

	// state is committed as the request moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_prev_q         <= 1'b1;
			press_start_q        <= 32'd0;
			pressed_event_time_q <= 32'd0;
			group_start_q        <= 32'd0;
			press_duration_q     <= 32'd0;
			pressed_flag_q       <= 1'b0;
			long_flag_q          <= 1'b0;
			clicks_q             <= 8'd0;
			last_type_q          <= TYPE_NONE;
		end else if (advance) begin
			level_prev_q         <= released_s1;
			press_start_q        <= press_start_d;
			pressed_event_time_q <= pressed_event_time_d;
			group_start_q        <= group_start_d;
			press_duration_q     <= press_duration_d;
			pressed_flag_q       <= pressed_flag_d;
			long_flag_q          <= long_flag_d;
			clicks_q             <= clicks_d;
			last_type_q          <= last_type_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ev_q         <= ev_d;
			clicks_out_q <= clicks_d;
			type_out_q   <= last_type_d;
		end
	end

	assign out_valid         = out_valid_q;
	assign event_res         = ev_q;
	assign press_duration_ms = press_duration_q;
	assign group_clicks      = clicks_out_q;
	assign click_type        = type_out_q;

endmodule

`default_nettype wire
